// ===== rtl/pwsa_pkg.sv =====
package pwsa_pkg;

    // Coefficient and register layout
    localparam int COEFF_W         = 21;
    localparam int CFG_DATA_W      = 63;
    localparam int CFG_ADDR_W      = 3;
    localparam int DIM_REG_W       = 12;
    localparam int FRAC_SHIFT      = 8;    // Q12.9 over Q4.17 -> scale numerator by 2^8
    localparam int MAX_DIM_DEFAULT = 2048;

    localparam logic [CFG_DATA_W-1:0] ROW0_RESET = 63'd512;
    localparam logic [CFG_DATA_W-1:0] ROW1_RESET = 63'd1073741824;
    localparam logic [CFG_DATA_W-1:0] ROW2_RESET = 63'd576460752303423488;
    localparam logic [DIM_REG_W-1:0]  DIM_RESET  = 12'd2048;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } cfg_reg_t;

    // Signed coefficient in slot k of a packed row register
    function automatic logic signed [COEFF_W-1:0] coeff_at(
        input logic [CFG_DATA_W-1:0] row,
        input int                    k
    );
        coeff_at = signed'(row[k*COEFF_W +: COEFF_W]);
    endfunction

endpackage

// ===== rtl/pwsa_map.sv =====
module pwsa_map
    import pwsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [$clog2(MAX_DIM)-1:0]             dest_x,
    input  logic [$clog2(MAX_DIM)-1:0]             dest_y,
    input  logic [CFG_DATA_W-1:0]                  row0,
    input  logic [CFG_DATA_W-1:0]                  row1,
    input  logic [CFG_DATA_W-1:0]                  row2,
    output logic                                   out_valid,
    output logic [COEFF_W+$clog2(MAX_DIM)+9:0]     num_u,
    output logic [COEFF_W+$clog2(MAX_DIM)+9:0]     num_v,
    output logic [COEFF_W+$clog2(MAX_DIM)+2:0]     den,
    output logic                                   bad
);

    localparam int OW   = $clog2(MAX_DIM);
    localparam int PW   = COEFF_W + OW + 1;
    localparam int WS   = PW + 2;
    localparam int NUMW = WS + FRAC_SHIFT - 1;
    localparam int DENW = WS - 1;

    logic [CFG_DATA_W-1:0]   rows [0:2];
    logic signed [OW:0]      xs;
    logic signed [OW:0]      ys;

    logic signed [PW-1:0]    prod_reg [0:2][0:1];
    logic signed [WS-1:0]    sum_reg  [0:2];
    logic [NUMW-1:0]         num_u_reg;
    logic [NUMW-1:0]         num_v_reg;
    logic [DENW-1:0]         den_reg;
    logic                    bad_reg;
    logic [2:0]              vld_reg;

    logic                    neg;
    logic signed [WS-1:0]    su;
    logic signed [WS-1:0]    sv;
    logic signed [WS-1:0]    sw;

    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;
    assign xs      = signed'({1'b0, dest_x});
    assign ys      = signed'({1'b0, dest_y});

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Stage 1: coefficient products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= coeff_at(rows[r], 0) * xs;
                prod_reg[r][1] <= coeff_at(rows[r], 1) * ys;
            end
        end
    end

    // Stage 2: row sums u, v, w
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= WS'(prod_reg[r][0]) + WS'(prod_reg[r][1])
                              + WS'(coeff_at(rows[r], 2));
            end
        end
    end

    // Stage 3: make the denominator positive
    always_comb
    begin
        neg = sum_reg[2][WS-1];
        su  = neg ? -sum_reg[0] : sum_reg[0];
        sv  = neg ? -sum_reg[1] : sum_reg[1];
        sw  = neg ? -sum_reg[2] : sum_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_u_reg <= {su[WS-2:0], {FRAC_SHIFT{1'b0}}};
            num_v_reg <= {sv[WS-2:0], {FRAC_SHIFT{1'b0}}};
            den_reg   <= sw[WS-2:0];
            bad_reg   <= (sum_reg[2] == '0) || su[WS-1] || sv[WS-1];
        end
    end

    assign out_valid = vld_reg[2];
    assign num_u     = num_u_reg;
    assign num_v     = num_v_reg;
    assign den       = den_reg;
    assign bad       = bad_reg;

endmodule

// ===== rtl/pwsa_place.sv =====
module pwsa_place
    import pwsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT,
    parameter int NUMW    = 42,
    parameter int DENW    = 34
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [NUMW-1:0]             num,
    input  logic [DENW-1:0]             den,
    input  logic                        bad,
    input  logic [$clog2(MAX_DIM):0]    dim,
    output logic                        in_range,
    output logic [$clog2(MAX_DIM)-1:0]  coord
);

    localparam int OW = $clog2(MAX_DIM);
    localparam int QB = OW + 1;
    localparam int CW = NUMW + QB + 1;

    logic [CW-1:0]   rem_reg [0:QB];
    logic [QB-1:0]   q_reg   [0:QB];
    logic [DENW-1:0] den_reg [0:QB];
    logic            ok_reg  [0:QB];
    logic            in_range_reg;
    logic [OW-1:0]   coord_reg;

    // Stage 0: quotient must fit in QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ok_reg[0]  <= !bad && (CW'(num) < (CW'(den) << QB));
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_step
        localparam int B = QB - 1 - j;
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(den_reg[j]) << B;
        assign ge  = rem_reg[j] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? rem_reg[j] - dsh : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (QB'(ge) << B);
                den_reg[j+1] <= den_reg[j];
                ok_reg[j+1]  <= ok_reg[j];
            end
        end
    end

    // Final stage: bound test, round half up, clamp to dim - 1
    logic          half;
    logic [QB:0]   rnd;
    logic [QB:0]   clamped;
    logic          in_now;

    always_comb
    begin
        half    = {rem_reg[QB][DENW-1:0], 1'b0} >= {1'b0, den_reg[QB]};
        rnd     = {1'b0, q_reg[QB]} + (QB+1)'(half);
        clamped = (rnd >= dim) ? dim - 1'b1 : rnd;
        in_now  = ok_reg[QB] && ({1'b0, q_reg[QB]} < dim);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_range_reg <= in_now;
            coord_reg    <= in_now ? clamped[OW-1:0] : '0;
        end
    end

    assign in_range = in_range_reg;
    assign coord    = coord_reg;

endmodule

// ===== rtl/pwsa_skid.sv =====
module pwsa_skid
    import pwsa_pkg::*;
#(
    parameter int DW = 23
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [DW-1:0] out_data_reg;
    logic [DW-1:0] skid_data_reg;
    logic          push;
    logic          room;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign room     = !out_valid_reg || out_ready;

    // Occupancy of output and skid entries
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        skid_valid_next = skid_valid_reg;
        if (push)
        begin
            if (room)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg && room)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && room)
        begin
            out_data_reg <= in_data;
        end
        else if (skid_valid_reg && room)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (push && !room)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/perspective_warp_source_address.sv =====
// Perspective warp source address (nearest neighbor).
// Input stream: one destination pixel (dest_x, dest_y) per transaction on s_axis.
// Output stream: one transaction per input on m_axis; tuser is 1 when the source
// pixel lies inside the source image, tdata carries the rounded source column
// and row (zero when outside).
// Configuration: cfg_we/cfg_addr/cfg_data write the three homography rows and
// the source width and height; write only while no transaction is in flight.
// Throughput: one transaction per clock while s_axis_tready is high. Pipeline
// from input acceptance to m_axis_tvalid: the multiply, sum and sign fix
// stages, the range check, a stage per quotient bit of the two pipelined
// restoring dividers, the round/clamp stage and the output register.
// Reset: clears all valid bits and loads the identity mapping at 2048x2048.
// Stall: a two-entry output buffer keeps accepting while a result waits; once
// its second entry fills, s_axis_tready drops and the whole pipeline holds.
module perspective_warp_source_address
    import pwsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // dest_x, dest_y from bit 0, zero padded
    input  logic [((2*$clog2(MAX_DIM)+7)/8)*8-1:0]  s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // source_x, source_y from bit 0, zero padded
    output logic [((2*$clog2(MAX_DIM)+7)/8)*8-1:0]  m_axis_tdata,
    output logic                                    m_axis_tuser,  // inside_res
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
    input  logic [CFG_DATA_W-1:0]                   cfg_data
);

    localparam int OW    = $clog2(MAX_DIM);
    localparam int QB    = OW + 1;
    localparam int TW    = ((2*OW+7)/8)*8;
    localparam int WS    = COEFF_W + OW + 3;
    localparam int NUMW  = WS + FRAC_SHIFT - 1;
    localparam int DENW  = WS - 1;
    localparam int DIMCW = (QB > DIM_REG_W) ? QB : DIM_REG_W;
    localparam int RW    = 1 + 2*OW;

    logic [CFG_DATA_W-1:0] row0_reg;
    logic [CFG_DATA_W-1:0] row1_reg;
    logic [CFG_DATA_W-1:0] row2_reg;
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;

    logic                  en;
    logic                  map_valid;
    logic [NUMW-1:0]       num_u;
    logic [NUMW-1:0]       num_v;
    logic [DENW-1:0]       den;
    logic                  bad;
    logic [QB-1:0]         dim_w;
    logic [QB-1:0]         dim_h;
    logic                  in_x;
    logic                  in_y;
    logic [OW-1:0]         src_x;
    logic [OW-1:0]         src_y;
    logic [QB+1:0]         vld_reg;
    logic [RW-1:0]         res_data;
    logic [RW-1:0]         out_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg   <= ROW0_RESET;
            row1_reg   <= ROW1_RESET;
            row2_reg   <= ROW2_RESET;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ROW0:   row0_reg   <= cfg_data;
                REG_ROW1:   row1_reg   <= cfg_data;
                REG_ROW2:   row2_reg   <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective dimensions, capped at MAX_DIM
    assign dim_w = (DIMCW'(width_reg) > DIMCW'(MAX_DIM)) ? QB'(MAX_DIM) : QB'(width_reg);
    assign dim_h = (DIMCW'(height_reg) > DIMCW'(MAX_DIM)) ? QB'(MAX_DIM) : QB'(height_reg);

    assign s_axis_tready = en;

    pwsa_map #(.MAX_DIM(MAX_DIM)) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .dest_x    (s_axis_tdata[OW-1:0]),
        .dest_y    (s_axis_tdata[2*OW-1:OW]),
        .row0      (row0_reg),
        .row1      (row1_reg),
        .row2      (row2_reg),
        .out_valid (map_valid),
        .num_u     (num_u),
        .num_v     (num_v),
        .den       (den),
        .bad       (bad)
    );

    pwsa_place #(.MAX_DIM(MAX_DIM), .NUMW(NUMW), .DENW(DENW)) u_place_x (
        .clk      (clk),
        .en       (en),
        .num      (num_u),
        .den      (den),
        .bad      (bad),
        .dim      (dim_w),
        .in_range (in_x),
        .coord    (src_x)
    );

    pwsa_place #(.MAX_DIM(MAX_DIM), .NUMW(NUMW), .DENW(DENW)) u_place_y (
        .clk      (clk),
        .en       (en),
        .num      (num_v),
        .den      (den),
        .bad      (bad),
        .dim      (dim_h),
        .in_range (in_y),
        .coord    (src_y)
    );

    // Valid bits alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB:0], map_valid};
        end
    end

    // Both coordinates must be inside
    assign res_data = (in_x && in_y) ? {1'b1, src_y, src_x} : '0;

    pwsa_skid #(.DW(RW)) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[QB+1]),
        .in_ready  (en),
        .in_data   (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tuser = out_data[RW-1];
    assign m_axis_tdata = TW'(out_data[2*OW-1:0]);

endmodule

// ===== rtl/pwsa_checker.sv =====
module pwsa_checker
    import pwsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    s_axis_tready,
    input logic [((2*$clog2(MAX_DIM)+7)/8)*8-1:0]  m_axis_tdata,
    input logic                                    m_axis_tuser,
    input logic                                    m_axis_tvalid,
    input logic                                    m_axis_tready
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Outside results carry zero coordinates
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("outside result with nonzero address");

    // Input side only backs up when an output transaction is waiting
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // Backpressure only builds from a refused output
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind perspective_warp_source_address pwsa_checker #(.MAX_DIM(MAX_DIM)) u_pwsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
